### rtl/crc16fr_pkg.sv
// Package for the CRC-16 frame receiver: item types, phase and status codes,
// and the bytewise CRC-16/MODBUS update. It depends on nothing else.
`default_nettype none

package crc16fr_pkg;

  localparam logic [7:0]  HDR_FIRST  = 8'h08;
  localparam logic [7:0]  HDR_SECOND = 8'h58;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [1:0]  MAX_LEN_RESET   = 2'd2;
  localparam logic [15:0] GAP_LIMIT_RESET = 16'd50;
  localparam logic [1:0]  PAYLOAD_DEPTH   = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HDR2 = 4'd1,
    PH_SEQ1 = 4'd2,
    PH_SEQ2 = 4'd3,
    PH_CMD1 = 4'd4,
    PH_CMD2 = 4'd5,
    PH_LEN1 = 4'd6,
    PH_LEN2 = 4'd7,
    PH_PAY  = 4'd8,
    PH_CRC1 = 4'd9,
    PH_CRC2 = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CRC = 2'd1,
    ST_LEN = 2'd2,
    ST_GAP = 2'd3
  } status_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] command;
    logic [1:0]  payload_len;
    logic [7:0]  payload_first;
    logic [7:0]  payload_second;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  max_payload_len;
    logic [15:0] gap_limit;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/crc16_frame_receiver.sv
// Top level of the CRC-16 frame receiver: APB registers, input and result
// registers around the parser. Depends on crc16fr_pkg and crc16fr_parser.
// Items pass the input register, then the parser, then the result register.
// Throughput: one byte or tick item per cycle unless an output stall holds it.
// Reset: parser idle, CRC at 0xFFFF, registers at their defaults (2 and 50).
`default_nettype none

module crc16_frame_receiver import crc16fr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  logic      step;
  logic      res_valid;
  out_item_t res;
  logic      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[2] ? {16'd0, cfg_q.gap_limit} : {30'd0, cfg_q.max_payload_len};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload_len <= MAX_LEN_RESET;
      cfg_q.gap_limit       <= GAP_LIMIT_RESET;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        cfg_q.gap_limit <= pwdata[15:0];
      end else begin
        cfg_q.max_payload_len <= pwdata[1:0];
      end
    end
  end

  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign step       = in_valid_q && !(out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  crc16fr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_err_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.payload_len == 2'd0) && (out_data_o.payload_first == 8'd0) &&
      (out_data_o.payload_second == 8'd0))
    else $error("error result carries payload");

  a_gap_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_GAP) |-> (out_data_o.command == 16'd0))
    else $error("gap timeout result carries a command");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.payload_len < 2'd2) |-> (out_data_o.payload_second == 8'd0))
    else $error("absent second payload byte is not zero");

  a_rise_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result appeared without an item in the input register");
`endif

endmodule

`default_nettype wire

### rtl/crc16fr_parser.sv
// Frame phase machine with running CRC, payload capture and gap counter.
// Depends on crc16fr_pkg for the item types, codes and the CRC update.
`default_nettype none

module crc16fr_parser import crc16fr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  input  wire cfg_t      cfg_i,
  output logic           res_valid_o,
  output out_item_t      res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] frame_cmd_q, frame_cmd_d;
  logic [7:0]  len_low_q, len_low_d;
  logic [1:0]  exp_len_q, exp_len_d;
  logic [1:0]  pay_cnt_q, pay_cnt_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic [15:0] gap_q, gap_d;
  logic [7:0]  pay_store_q [PAYLOAD_DEPTH];
  logic        pay_we;

  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [1:0]  limit;
  logic [16:0] gap_inc;
  logic [1:0]  pay_cnt_inc;
  logic [1:0]  n_ok;

  assign b           = item_i.rx_byte;
  assign crc_upd     = crc_byte(crc_q, b);
  assign len_full    = {b, len_low_q};
  assign limit       = (cfg_i.max_payload_len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH
                                                               : cfg_i.max_payload_len;
  assign gap_inc     = {1'b0, gap_q} + 17'd1;
  assign pay_cnt_inc = pay_cnt_q + 2'd1;
  assign n_ok        = (pay_cnt_q > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : pay_cnt_q;

  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    frame_cmd_d = frame_cmd_q;
    len_low_d   = len_low_q;
    exp_len_d   = exp_len_q;
    pay_cnt_d   = pay_cnt_q;
    crc_low_d   = crc_low_q;
    gap_d       = gap_q;
    pay_we      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (item_i.cmd == CMD_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (gap_inc > {1'b0, cfg_i.gap_limit}) begin
            phase_d     = PH_IDLE;
            crc_d       = CRC_INIT;
            frame_cmd_d = '0;
            len_low_d   = '0;
            exp_len_d   = '0;
            pay_cnt_d   = '0;
            crc_low_d   = '0;
            gap_d       = '0;
            res_valid_o = 1'b1;
            res_o.status = ST_GAP;
          end else begin
            gap_d = gap_inc[15:0];
          end
        end
      end else begin
        gap_d = '0;
        unique case (phase_q)
          PH_IDLE: begin
            if (b == HDR_FIRST) begin
              crc_d       = crc_byte(CRC_INIT, b);
              frame_cmd_d = '0;
              len_low_d   = '0;
              exp_len_d   = '0;
              pay_cnt_d   = '0;
              crc_low_d   = '0;
              phase_d     = PH_HDR2;
            end
          end
          PH_HDR2: begin
            if (b == HDR_SECOND) begin
              crc_d   = crc_upd;
              phase_d = PH_SEQ1;
            end else begin
              phase_d = PH_IDLE;
              crc_d   = CRC_INIT;
            end
          end
          PH_SEQ1: begin
            crc_d   = crc_upd;
            phase_d = PH_SEQ2;
          end
          PH_SEQ2: begin
            crc_d   = crc_upd;
            phase_d = PH_CMD1;
          end
          PH_CMD1: begin
            crc_d       = crc_upd;
            frame_cmd_d = {8'h00, b};
            phase_d     = PH_CMD2;
          end
          PH_CMD2: begin
            crc_d       = crc_upd;
            frame_cmd_d = {b, frame_cmd_q[7:0]};
            phase_d     = PH_LEN1;
          end
          PH_LEN1: begin
            crc_d     = crc_upd;
            len_low_d = b;
            phase_d   = PH_LEN2;
          end
          PH_LEN2: begin
            crc_d     = crc_upd;
            pay_cnt_d = '0;
            if (len_full == 16'd0) begin
              exp_len_d = '0;
              phase_d   = PH_CRC1;
            end else if (len_full > {14'd0, limit}) begin
              phase_d      = PH_IDLE;
              crc_d        = CRC_INIT;
              frame_cmd_d  = '0;
              len_low_d    = '0;
              exp_len_d    = '0;
              crc_low_d    = '0;
              res_valid_o  = 1'b1;
              res_o.status = ST_LEN;
              res_o.command = frame_cmd_q;
            end else begin
              exp_len_d = len_full[1:0];
              phase_d   = PH_PAY;
            end
          end
          PH_PAY: begin
            crc_d     = crc_upd;
            pay_we    = 1'b1;
            pay_cnt_d = pay_cnt_inc;
            if (pay_cnt_inc >= exp_len_q) begin
              phase_d = PH_CRC1;
            end
          end
          PH_CRC1: begin
            crc_low_d = b;
            phase_d   = PH_CRC2;
          end
          PH_CRC2: begin
            res_valid_o   = 1'b1;
            res_o.command = frame_cmd_q;
            if ({b, crc_low_q} == crc_q) begin
              res_o.status      = ST_OK;
              res_o.payload_len = n_ok;
              if (n_ok >= 2'd1) begin
                res_o.payload_first = pay_store_q[0];
              end
              if (n_ok >= 2'd2) begin
                res_o.payload_second = pay_store_q[1];
              end
            end else begin
              res_o.status = ST_CRC;
            end
            phase_d     = PH_IDLE;
            crc_d       = CRC_INIT;
            frame_cmd_d = '0;
            len_low_d   = '0;
            exp_len_d   = '0;
            pay_cnt_d   = '0;
            crc_low_d   = '0;
          end
          default: begin
            phase_d     = PH_IDLE;
            crc_d       = CRC_INIT;
            frame_cmd_d = '0;
            len_low_d   = '0;
            exp_len_d   = '0;
            pay_cnt_d   = '0;
            crc_low_d   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      crc_q       <= CRC_INIT;
      frame_cmd_q <= '0;
      len_low_q   <= '0;
      exp_len_q   <= '0;
      pay_cnt_q   <= '0;
      crc_low_q   <= '0;
      gap_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      frame_cmd_q <= frame_cmd_d;
      len_low_q   <= len_low_d;
      exp_len_q   <= exp_len_d;
      pay_cnt_q   <= pay_cnt_d;
      crc_low_q   <= crc_low_d;
      gap_q       <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_store_q[pay_cnt_q[0]] <= b;
    end
  end

endmodule

`default_nettype wire
